// ===== rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Types and codes shared by the slab slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_REAP  = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic REG_OBJECT_BYTES = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  localparam int unsigned MIN_OBJECT_BYTES = 4;
  localparam int unsigned BYTES_MAX        = 524287;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] handle;
  } ssa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  granted_handle;
    logic [18:0] reclaimed_bytes;
    logic [6:0]  live_count;
    logic [6:0]  free_count;
    logic [6:0]  peak_count;
  } ssa_out_t;
endpackage

// ===== rtl/ssa_stack_ram.sv =====
// ----------------------------------------------------------------------------
// ssa_stack_ram
// Free stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssa_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/slab_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// slab_slot_allocator_top
// Slab slot allocator with a LIFO free stack held in a synchronous memory.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. busy stays high from the accepting edge
// until the result beat has been on the result ports.
// - A free goes from the accepting edge straight to the output state, which
//   registers the result and its strobe.
// - An allocate from a non-empty stack needs one memory read first, then
//   pops the top in S_POP before the output state.
// - An allocate that activates a block first pushes its slots, one a cycle,
//   then reads back the new top in S_PRD before the pop.
// - A reap visits each block in turn. For each released block it compacts
//   the whole free stack through the one stack memory, taking each stack
//   entry through S_RWR and S_RRD. It then goes to the output state.
// The result strobe out_valid lasts one cycle. The receiver cannot stall
// it, so every result has to be taken in the cycle it is shown.
module slab_slot_allocator_top #(
  parameter int NUM_BLOCKS      = 8,
  parameter int SLOTS_PER_BLOCK = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ssa_pkg::ssa_in_t in_data,
  output logic             out_valid,
  output ssa_pkg::ssa_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [12:0]      cfg_data
);
  import ssa_pkg::*;

  localparam int TOTAL = NUM_BLOCKS * SLOTS_PER_BLOCK;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SW    = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int FW    = $clog2(SLOTS_PER_BLOCK + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_RSCN = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_RWR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_PRD  = 3'd7;

  logic [2:0]     state_r;
  logic [12:0]    obj_r;
  logic [7:0]     hdr_r;
  logic [CW-1:0]  depth_r, live_r, peak_r;
  logic [NUM_BLOCKS-1:0] act_r;
  logic [FW-1:0]  bfree_r [NUM_BLOCKS];
  logic [TOTAL-1:0] sfree_r;
  logic [BW-1:0]  blk_r;
  logic [SW-1:0]  fcnt_r;
  logic [CW-1:0]  ridx_r, keep_r;
  logic [19:0]    total_r;
  logic [1:0]     mode_r;
  ssa_out_t       res_r;
  logic           ov_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [AW-1:0] wdata, rdata;

  ssa_stack_ram #(.DEPTH(TOTAL), .AW(AW), .DW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [BW-1:0] low_inact;
  logic          any_inact;
  always_comb begin
    low_inact = '0;
    any_inact = 1'b0;
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      if (!act_r[b]) begin
        low_inact = BW'(b);
        any_inact = 1'b1;
      end
    end
  end

  logic [BW-1:0] hblk;
  logic          hin;
  logic [BW-1:0] rblk;
  assign hin  = {1'b0, in_data.handle} < (AW + 1)'(TOTAL);
  assign hblk = BW'(in_data.handle[AW-1:0] / SLOTS_PER_BLOCK);
  assign rblk = BW'(rdata / SLOTS_PER_BLOCK);

  logic [18:0] per_blk;
  always_comb begin
    logic [12:0] ob;
    ob = (obj_r < 13'(MIN_OBJECT_BYTES)) ? 13'(MIN_OBJECT_BYTES) : obj_r;
    per_blk = 19'(ob * SLOTS_PER_BLOCK) + 19'(hdr_r);
  end

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE) || ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  logic reap_hit;
  assign reap_hit = act_r[blk_r] && (bfree_r[blk_r] == FW'(SLOTS_PER_BLOCK));

  always_comb begin
    we    = 1'b0;
    waddr = depth_r[AW-1:0];
    wdata = '0;
    raddr = AW'(depth_r - 1'b1);
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.mode == MODE_FREE && hin && act_r[hblk] &&
            !sfree_r[in_data.handle[AW-1:0]]) begin
          we    = depth_r < CW'(TOTAL);
          wdata = in_data.handle[AW-1:0];
        end
      end
      S_FILL: begin
        we    = depth_r < CW'(TOTAL);
        wdata = AW'(blk_r * SLOTS_PER_BLOCK + fcnt_r);
      end
      S_RSCN, S_RWR: raddr = ridx_r[AW-1:0];
      S_RRD: begin
        raddr = ridx_r[AW-1:0];
        we    = rblk != blk_r;
        waddr = keep_r[AW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      obj_r   <= 13'd4;
      hdr_r   <= 8'd16;
      depth_r <= '0;
      live_r  <= '0;
      peak_r  <= '0;
      act_r   <= '0;
      sfree_r <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) bfree_r[b] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OBJECT_BYTES) obj_r <= cfg_data;
        else                               hdr_r <= cfg_data[7:0];
      end
      ov_r <= (state_r == S_OUT);
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r <= in_data.mode;
            res_r.granted_handle  <= '0;
            res_r.reclaimed_bytes <= '0;
            case (in_data.mode)
              MODE_ALLOC: begin
                if (depth_r != '0) begin
                  res_r.status <= ST_OK;
                  state_r <= S_POP;
                end else if (any_inact) begin
                  act_r[low_inact]   <= 1'b1;
                  bfree_r[low_inact] <= FW'(SLOTS_PER_BLOCK);
                  blk_r  <= low_inact;
                  fcnt_r <= '0;
                  res_r.status <= ST_OK;
                  state_r <= S_FILL;
                end else begin
                  res_r.status <= ST_OOM;
                  state_r <= S_OUT;
                end
              end
              MODE_FREE: begin
                if (hin && act_r[hblk] && !sfree_r[in_data.handle[AW-1:0]]) begin
                  if (depth_r < CW'(TOTAL)) begin
                    depth_r <= depth_r + 1'b1;
                    sfree_r[in_data.handle[AW-1:0]] <= 1'b1;
                  end
                  bfree_r[hblk] <= bfree_r[hblk] + 1'b1;
                  if (live_r != '0) live_r <= live_r - 1'b1;
                  res_r.status <= ST_OK;
                end else begin
                  res_r.status <= ST_BAD;
                end
                state_r <= S_OUT;
              end
              MODE_REAP: begin
                blk_r   <= '0;
                total_r <= '0;
                res_r.status <= ST_OK;
                state_r <= S_RSCN;
              end
              default: begin
                res_r.status <= ST_BAD;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_FILL: begin
          if (depth_r < CW'(TOTAL)) begin
            depth_r <= depth_r + 1'b1;
            sfree_r[AW'(blk_r * SLOTS_PER_BLOCK + fcnt_r)] <= 1'b1;
          end
          fcnt_r <= fcnt_r + 1'b1;
          if (fcnt_r == SW'(SLOTS_PER_BLOCK - 1)) state_r <= S_PRD;
        end
        // The last slot is written as the fill ends, so the top is read here.
        S_PRD: state_r <= S_POP;
        S_POP: begin
          // rdata holds the top entry, read in the previous cycle.
          depth_r <= depth_r - 1'b1;
          sfree_r[rdata] <= 1'b0;
          if (bfree_r[rblk] != '0) bfree_r[rblk] <= bfree_r[rblk] - 1'b1;
          live_r <= live_r + 1'b1;
          if (live_r + 1'b1 > peak_r) peak_r <= live_r + 1'b1;
          res_r.granted_handle <= 6'(rdata);
          state_r <= S_OUT;
        end
        S_RSCN: begin
          if (reap_hit) begin
            ridx_r  <= '0;
            keep_r  <= '0;
            act_r[blk_r]   <= 1'b0;
            bfree_r[blk_r] <= '0;
            total_r <= total_r + 20'(per_blk);
            if (depth_r != '0) begin
              state_r <= S_RWR;
            end else if (blk_r == BW'(NUM_BLOCKS - 1)) begin
              state_r <= S_OUT;
            end else begin
              blk_r <= blk_r + 1'b1;
            end
          end else if (blk_r == BW'(NUM_BLOCKS - 1)) begin
            state_r <= S_OUT;
          end else begin
            blk_r <= blk_r + 1'b1;
          end
        end
        S_RWR: state_r <= S_RRD;
        S_RRD: begin
          if (rblk == blk_r) sfree_r[rdata] <= 1'b0;
          else keep_r <= keep_r + 1'b1;
          if (ridx_r + 1'b1 == depth_r) begin
            depth_r <= keep_r + CW'(rblk != blk_r);
            if (blk_r == BW'(NUM_BLOCKS - 1)) begin
              state_r <= S_OUT;
            end else begin
              blk_r   <= blk_r + 1'b1;
              state_r <= S_RSCN;
            end
          end else begin
            ridx_r  <= ridx_r + 1'b1;
            state_r <= S_RWR;
          end
        end
        S_OUT: begin
          if (mode_r == MODE_REAP)
            res_r.reclaimed_bytes <= (total_r > 20'(BYTES_MAX)) ? 19'(BYTES_MAX)
                                                                : total_r[18:0];
          res_r.live_count <= 7'(live_r);
          res_r.free_count <= 7'(depth_r);
          res_r.peak_count <= 7'(peak_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_live_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= peak_r) else $error("live count above peak");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(TOTAL)) else $error("stack depth overflow");
  a_no_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !accept) else $error("accept during result");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
`endif
endmodule
